// File: rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types, constants and helpers of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int REGION_BYTES  = 65536;
    localparam int GRANULE_BYTES = 8;
    localparam int HEADER_BYTES  = 16;

    // Header span rounded up to whole granules
    localparam int HDR_SPAN    = ((HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES)
                                 * GRANULE_BYTES;
    localparam int STORE_DEPTH = REGION_BYTES / GRANULE_BYTES;
    localparam int GRAN_SH     = $clog2(GRANULE_BYTES);
    localparam int SLOT_W      = $clog2(STORE_DEPTH);

    // Offsets, sizes and limits: 0 .. 65536 inclusive
    localparam int OFF_W   = 17;
    localparam int SUM_W   = OFF_W + 2;
    localparam int PAY_W   = 16;
    localparam int HDR_W   = OFF_W + 1;

    localparam logic [OFF_W-1:0] REGION_END = OFF_W'(REGION_BYTES);
    localparam logic [OFF_W-1:0] HDR_OFF    = OFF_W'(HDR_SPAN);
    localparam logic [OFF_W-1:0] GRAN_OFF   = OFF_W'(GRANULE_BYTES);

    // Stream widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t               op;
        logic [OFF_W-1:0]  n;
        logic [PAY_W-1:0]  free_off;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_A_TAKE,
        ST_A_APPEND,
        ST_F_RD,
        ST_F_CHK,
        ST_F_HDR_CHK,
        ST_C_RD,
        ST_C_CHK,
        ST_C_NXT_CHK,
        ST_DONE
    } state_t;

    // Header slot of a granule-aligned offset
    function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] off);
        return off[GRAN_SH +: SLOT_W];
    endfunction

endpackage

// File: rtl/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ffra_front.sv
// ----------------------------------------------------------------------------
// ffra_front
// Accepts input items, classifies the op, rounds the request to the granule
// and holds commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module ffra_front
    import ffra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [1:0] op, [18:2] alloc_bytes, [34:19] free_offset
    input  logic [IN_TDATA_W-1:0] s_tdata,
    output cmd_t                  cmd,
    output logic                  cmd_valid,
    input  logic                  cmd_pop
);

    cmd_t               q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;

    logic [1:0]        in_op;
    logic [OFF_W-1:0]  in_bytes;
    logic [PAY_W-1:0]  in_free;
    logic [OFF_W-1:0]  req;
    logic [OFF_W:0]    rounded;
    cmd_t              cmd_in;
    logic              push;
    logic              pop;

    assign in_op    = s_tdata[1:0];
    assign in_bytes = s_tdata[18:2];
    assign in_free  = s_tdata[34:19];

    // Classify the op and round the request up to whole granules
    always_comb
    begin
        req     = (in_bytes == '0) ? GRAN_OFF : in_bytes;
        rounded = ({1'b0, req} + {1'b0, GRAN_OFF} - (OFF_W+1)'(1))
                  & ~(OFF_W+1)'(GRANULE_BYTES - 1);
        // Saturate a request rounded past the field width; it can never fit
        cmd_in.n        = rounded[OFF_W] ? '1 : rounded[OFF_W-1:0];
        cmd_in.free_off = in_free;
        unique case (in_op)
            OP_ALLOC: cmd_in.op = OP_ALLOC;
            OP_FREE:  cmd_in.op = OP_FREE;
            default:  cmd_in.op = OP_QUERY;
        endcase
    end

    assign s_tready  = (count_reg != (Q_PTR_W+1)'(Q_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_pop && cmd_valid;

    // Advance queue pointers
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: rtl/ffra_back.sv
// ----------------------------------------------------------------------------
// ffra_back
// Walks the header store to allocate, free, coalesce and trim, and holds the
// result item in an output register.
// ----------------------------------------------------------------------------
module ffra_back
    import ffra_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    input  logic                   cmd_valid,
    output logic                   cmd_pop,
    input  logic [OFF_W-1:0]       limit_top,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] ok, [16:1] payload_offset, [33:17] used_bytes,
    // [50:34] free_bytes, [67:51] high_water
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [OFF_W-1:0]  n_reg, n_next;
    logic [OFF_W-1:0]  hp_reg, hp_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [OFF_W-1:0]  sz_reg, sz_next;
    logic [OFF_W-1:0]  last_off_reg, last_off_next;
    logic              last_used_reg, last_used_next;
    logic [OFF_W-1:0]  end_reg, end_next;
    logic [OFF_W-1:0]  bytes_reg, bytes_next;
    logic [OFF_W-1:0]  high_reg, high_next;
    logic              ok_reg, ok_next;
    logic [PAY_W-1:0]  pay_reg, pay_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [HDR_W-1:0]  ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    logic [HDR_W-1:0]  ram_rdata;

    logic [OFF_W-1:0]  rd_size;
    logic              rd_used;
    logic [OFF_W-1:0]  lim;
    logic [OFF_W-1:0]  gap;
    logic [OFF_W-1:0]  mid;
    logic [SUM_W-1:0]  step_rd;
    logic [SUM_W-1:0]  step_sz;
    logic [SUM_W-1:0]  need;
    logic [SUM_W-1:0]  split_need;
    logic [SUM_W-1:0]  app_end;
    logic              out_free;
    logic [PAY_W-1:0]  free_hdr;

    ffra_ram #(
        .WIDTH(HDR_W),
        .DEPTH(STORE_DEPTH)
    ) u_hdr_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_size = ram_rdata[OFF_W-1:0];
    assign rd_used = ram_rdata[OFF_W];

    // Shared arithmetic of the walk
    always_comb
    begin
        lim        = (limit_top > REGION_END) ? REGION_END : limit_top;
        gap        = (lim > end_reg) ? lim - end_reg : '0;
        mid        = (gap > HDR_OFF) ? gap - HDR_OFF : '0;
        step_rd    = SUM_W'(off_reg) + SUM_W'(HDR_OFF) + SUM_W'(rd_size);
        step_sz    = SUM_W'(off_reg) + SUM_W'(HDR_OFF) + SUM_W'(sz_reg);
        need       = SUM_W'(n_reg);
        split_need = SUM_W'(n_reg) + SUM_W'(HDR_OFF) + SUM_W'(GRAN_OFF);
        app_end    = SUM_W'(end_reg) + SUM_W'(HDR_OFF) + SUM_W'(n_reg);
        out_free   = !out_valid_reg || m_tready;
        free_hdr   = cmd.free_off - PAY_W'(HDR_SPAN);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_ALLOC: state_next = ST_A_RD;
                        OP_FREE:  state_next = (cmd.free_off < PAY_W'(HDR_SPAN)) ?
                                               ST_DONE : ST_F_RD;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_A_RD:      state_next = (off_reg < end_reg) ? ST_A_CHK : ST_A_APPEND;
            ST_A_CHK:     state_next = (!rd_used && SUM_W'(rd_size) >= need) ?
                                       ST_A_TAKE : ST_A_RD;
            ST_A_TAKE:    state_next = ST_DONE;
            ST_A_APPEND:  state_next = ST_DONE;
            ST_F_RD:
            begin
                priority if (off_reg < end_reg && off_reg < hp_reg)
                    state_next = ST_F_CHK;
                else if (off_reg != hp_reg || off_reg >= end_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_F_HDR_CHK;
            end
            ST_F_CHK:     state_next = ST_F_RD;
            ST_F_HDR_CHK: state_next = rd_used ? ST_C_RD : ST_DONE;
            ST_C_RD:      state_next = (off_reg < end_reg) ? ST_C_CHK : ST_DONE;
            ST_C_CHK:     state_next = (!rd_used && step_rd < SUM_W'(end_reg)) ?
                                       ST_C_NXT_CHK : ST_C_RD;
            ST_C_NXT_CHK: state_next = ST_C_RD;
            ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath, header store access and result
    always_comb
    begin
        op_next        = op_reg;
        n_next         = n_reg;
        hp_next        = hp_reg;
        off_next       = off_reg;
        sz_next        = sz_reg;
        last_off_next  = last_off_reg;
        last_used_next = last_used_reg;
        end_next       = end_reg;
        bytes_next     = bytes_reg;
        high_next      = high_reg;
        ok_next        = ok_reg;
        pay_next       = pay_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = slot_of(off_reg);
        ram_wdata      = '0;
        ram_raddr      = slot_of(off_reg);

        // Drop a delivered result
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop        = 1'b1;
                    op_next        = cmd.op;
                    n_next         = cmd.n;
                    hp_next        = OFF_W'(free_hdr);
                    off_next       = '0;
                    last_off_next  = '0;
                    last_used_next = 1'b1;
                    ok_next        = 1'b1;
                    pay_next       = '0;
                end
            end
            ST_A_RD:
            begin
                ram_raddr = slot_of(off_reg);
            end
            ST_A_CHK:
            begin
                if (!rd_used && SUM_W'(rd_size) >= need)
                begin
                    // Split off the remainder as a free block
                    if (SUM_W'(rd_size) >= split_need)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_of(off_reg + HDR_OFF + n_reg);
                        ram_wdata = {1'b0, rd_size - n_reg - HDR_OFF};
                        sz_next   = n_reg;
                    end
                    else
                    begin
                        sz_next = rd_size;
                    end
                end
                else
                begin
                    off_next = step_rd[OFF_W-1:0];
                end
            end
            ST_A_TAKE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_of(off_reg);
                ram_wdata  = {1'b1, sz_reg};
                bytes_next = bytes_reg + sz_reg;
                pay_next   = PAY_W'(off_reg + HDR_OFF);
            end
            ST_A_APPEND:
            begin
                // Append at the end when it stays within the limit
                if (app_end <= SUM_W'(lim))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_of(end_reg);
                    ram_wdata  = {1'b1, n_reg};
                    end_next   = app_end[OFF_W-1:0];
                    high_next  = (app_end[OFF_W-1:0] > high_reg) ? app_end[OFF_W-1:0] :
                                 high_reg;
                    bytes_next = bytes_reg + n_reg;
                    pay_next   = PAY_W'(end_reg + HDR_OFF);
                end
                else
                begin
                    ok_next = 1'b0;
                end
            end
            ST_F_RD:
            begin
                ram_raddr = slot_of(off_reg);
            end
            ST_F_CHK:
            begin
                off_next = step_rd[OFF_W-1:0];
            end
            ST_F_HDR_CHK:
            begin
                // Release a live block and restart from the bottom
                if (rd_used)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_of(off_reg);
                    ram_wdata  = {1'b0, rd_size};
                    bytes_next = (bytes_reg >= rd_size) ? bytes_reg - rd_size : bytes_reg;
                    off_next   = '0;
                end
            end
            ST_C_RD:
            begin
                ram_raddr = slot_of(off_reg);
                // Trim a trailing free block
                if (off_reg >= end_reg && end_reg != '0 && !last_used_reg)
                begin
                    end_next = last_off_reg;
                end
            end
            ST_C_CHK:
            begin
                sz_next = rd_size;
                if (!rd_used && step_rd < SUM_W'(end_reg))
                begin
                    ram_raddr = slot_of(step_rd[OFF_W-1:0]);
                end
                else
                begin
                    last_off_next  = off_reg;
                    last_used_next = rd_used;
                    off_next       = step_rd[OFF_W-1:0];
                end
            end
            ST_C_NXT_CHK:
            begin
                // Merge with a free neighbor, else move on
                if (!rd_used)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(off_reg);
                    ram_wdata = {1'b0, sz_reg + HDR_OFF + rd_size};
                end
                else
                begin
                    last_off_next  = off_reg;
                    last_used_next = 1'b0;
                    off_next       = step_sz[OFF_W-1:0];
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_W'({high_reg, mid, bytes_reg,
                                                   pay_reg, ok_reg});
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            end_reg       <= '0;
            bytes_reg     <= '0;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            end_reg       <= end_next;
            bytes_reg     <= bytes_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        n_reg         <= n_next;
        hp_reg        <= hp_next;
        off_reg       <= off_next;
        sz_reg        <= sz_next;
        last_off_reg  <= last_off_next;
        last_used_reg <= last_used_next;
        ok_reg        <= ok_next;
        pay_reg       <= pay_next;
        out_data_reg  <= out_data_next;
    end

    a_end_below_high: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg <= high_reg)
        else $error("region end above high-water mark");

    a_end_in_region: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg <= REGION_END)
        else $error("region end beyond region");

    a_used_below_end: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg <= end_reg)
        else $error("bytes in use exceed region end");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !ram_we)
        else $error("header write outside a walk");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg != ST_IDLE) && (op_reg != OP_ALLOC ||
                     state_reg == ST_A_RD))
        else $error("command popped outside idle");

endmodule

// File: rtl/first_fit_region_allocator.sv
// Sequence: alloc walks the blocks, then takes a fitting free block or appends;
//   free walks the blocks up to the freed one, then, if it released a live block,
//   runs the merge and trim pass; each result is then loaded into the output register.
// Throughput: one item at a time in the back end; the header store's single
//   registered read port sets the per-block cost. A 2-item queue feeds it.
// Reset: control, end, usage and high-water clear; header store is not cleared.
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator over a byte region with coalescing of free neighbors.
// ----------------------------------------------------------------------------
module first_fit_region_allocator
    import ffra_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [1:0] op, [18:2] alloc_bytes, [34:19] free_offset
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] ok, [16:1] payload_offset, [33:17] used_bytes,
    // [50:34] free_bytes, [67:51] high_water
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [OFF_W-1:0]       cfg_data
);

    logic [OFF_W-1:0] limit_reg;
    cmd_t             cmd;
    logic             cmd_valid;
    logic             cmd_pop;

    assign cfg_ready = 1'b1;

    // Hold the limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= REGION_END;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    ffra_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .cmd_valid(cmd_valid),
        .cmd_pop  (cmd_pop)
    );

    ffra_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cmd_valid(cmd_valid),
        .cmd_pop  (cmd_pop),
        .limit_top(limit_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, free and query items into the region allocator, predicts
// every result with a local model of the block headers, and compares.
// ----------------------------------------------------------------------------
module testbench;
    import ffra_pkg::*;

    localparam int WATCHDOG_CYCLES = 200000;

    typedef struct packed {
        logic [OFF_W-1:0]  high;
        logic [OFF_W-1:0]  avail;
        logic [OFF_W-1:0]  used;
        logic [PAY_W-1:0]  payload;
        logic              ok;
    } result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [OFF_W-1:0]       cfg_data;

    // Predictor state: headers indexed by granule slot
    int unsigned hdr_size [STORE_DEPTH];
    bit          hdr_used [STORE_DEPTH];
    int unsigned model_end;
    int unsigned model_in_use;
    int unsigned model_high;
    int unsigned model_limit;

    // Payload offsets currently held, to aim frees at live blocks
    int unsigned live_offsets[$];
    result_t     expected_results[$];

    int  error_count;
    int  results_seen;
    int  idle_count;
    bit  idle_enabled;
    bit  hold_sink;
    int  sink_hold_cycles;

    first_fit_region_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned slot(input int unsigned off);
        int unsigned i;
        i = off / GRANULE_BYTES;
        return (i < STORE_DEPTH) ? i : 0;
    endfunction

    function automatic void write_hdr(input int unsigned off, input int unsigned size,
                                      input bit used);
        hdr_size[slot(off)] = size & 32'h1FFFF;
        hdr_used[slot(off)] = used;
    endfunction

    function automatic int unsigned usable_limit();
        return (model_limit > REGION_BYTES) ? REGION_BYTES : model_limit;
    endfunction

    // First-fit walk, split, else append
    function automatic int unsigned model_alloc(input int unsigned req, output bit ok);
        int unsigned n;
        int unsigned off;
        int unsigned sz;
        int unsigned at;
        n = (req == 0) ? GRANULE_BYTES : req;
        n = ((n + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
        off = 0;
        ok = 1'b1;
        while (off < model_end)
        begin
            sz = hdr_size[slot(off)];
            if (!hdr_used[slot(off)] && sz >= n)
            begin
                if (sz >= n + HDR_SPAN + GRANULE_BYTES)
                begin
                    write_hdr(off + HDR_SPAN + n, sz - n - HDR_SPAN, 1'b0);
                    sz = n;
                end
                write_hdr(off, sz, 1'b1);
                model_in_use += sz;
                return off + HDR_SPAN;
            end
            off += HDR_SPAN + sz;
        end
        if (model_end + HDR_SPAN + n <= usable_limit())
        begin
            at = model_end;
            write_hdr(at, n, 1'b1);
            model_end += HDR_SPAN + n;
            if (model_end > model_high)
                model_high = model_end;
            model_in_use += n;
            return at + HDR_SPAN;
        end
        ok = 1'b0;
        return 0;
    endfunction

    // Release a live block, merge free runs, wind back a trailing free block
    function automatic void model_free(input int unsigned p);
        int unsigned hp;
        int unsigned off;
        int unsigned sz;
        int unsigned nxt;
        int unsigned last;
        if (p < HDR_SPAN)
            return;
        hp = p - HDR_SPAN;
        off = 0;
        while (off < model_end && off < hp)
            off += HDR_SPAN + hdr_size[slot(off)];
        if (off != hp || off >= model_end || !hdr_used[slot(off)])
            return;
        hdr_used[slot(off)] = 1'b0;
        if (model_in_use >= hdr_size[slot(off)])
            model_in_use -= hdr_size[slot(off)];
        off = 0;
        while (off < model_end)
        begin
            sz = hdr_size[slot(off)];
            nxt = off + HDR_SPAN + sz;
            if (!hdr_used[slot(off)] && nxt < model_end && !hdr_used[slot(nxt)])
                write_hdr(off, sz + HDR_SPAN + hdr_size[slot(nxt)], 1'b0);
            else
                off = nxt;
        end
        off = 0;
        last = 0;
        while (off < model_end)
        begin
            last = off;
            off += HDR_SPAN + hdr_size[slot(off)];
        end
        if (model_end > 0 && !hdr_used[slot(last)])
            model_end = last;
    endfunction

    function automatic result_t predict_allocation(input logic [1:0] op,
                                                   input int unsigned req,
                                                   input int unsigned foff);
        result_t r;
        bit ok;
        int unsigned pay;
        int unsigned lim;
        int unsigned gap;
        ok = 1'b1;
        pay = 0;
        if (op == OP_ALLOC)
        begin
            pay = model_alloc(req, ok);
            if (ok)
                live_offsets.push_back(pay);
        end
        else if (op == OP_FREE)
        begin
            model_free(foff);
            foreach (live_offsets[i])
                if (live_offsets[i] == foff)
                begin
                    live_offsets.delete(i);
                    break;
                end
        end
        lim = usable_limit();
        gap = (lim > model_end) ? lim - model_end : 0;
        gap = (gap > HDR_SPAN) ? gap - HDR_SPAN : 0;
        r.ok = ok;
        r.payload = pay[PAY_W-1:0];
        r.used = model_in_use[OFF_W-1:0];
        r.avail = gap[OFF_W-1:0];
        r.high = model_high[OFF_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch in result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // Send one item, predicting its result at the handshake; valid stays up
    // for a following item and is dropped by an idle gap or a drain
    task automatic send_item(input logic [1:0] op, input int unsigned req,
                             input int unsigned foff);
        int gap;
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, foff[15:0], req[16:0], op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(predict_allocation(op, req, foff));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // Settle before a limit change
        repeat (400) @(posedge clk);
    endtask

    task automatic set_limit(input int unsigned value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value[OFF_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_limit = value & 32'h1FFFF;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int unsigned pick_free_offset();
        int k;
        k = $urandom_range(0, 9);
        if (live_offsets.size() != 0 && k < 8)
            return live_offsets[$urandom_range(0, live_offsets.size() - 1)];
        if (k == 8)
            return $urandom_range(0, 65535);
        return $urandom_range(0, 40) * GRANULE_BYTES;
    endfunction

    // Field extremes, every op, odd ops, non-live frees, oversized requests
    task automatic test_directed();
        send_item(OP_QUERY, 0, 0);
        send_item(OP_ALLOC, 0, 0);
        send_item(OP_ALLOC, 1, 0);
        send_item(OP_ALLOC, 9, 0);
        send_item(OP_ALLOC, 65536, 0);
        send_item(OP_ALLOC, 131071, 65535);
        send_item(OP_FREE, 0, 0);
        send_item(OP_FREE, 0, 65535);
        send_item(OP_FREE, 0, 20);
        send_item(2'd3, 131071, 65535);
        send_item(OP_FREE, 0, 16);
        send_item(OP_FREE, 0, 40);
        send_item(OP_FREE, 0, 16);
        send_item(OP_ALLOC, 200, 0);
        send_item(OP_ALLOC, 8, 0);
        send_item(OP_ALLOC, 65000, 0);
        send_item(OP_ALLOC, 32, 0);
        send_item(OP_FREE, 0, 16);
        send_item(OP_FREE, 0, 232);
        send_item(OP_ALLOC, 64, 0);
    endtask

    // Tight limits, including one below the current end and the extremes
    task automatic test_limits();
        set_limit(200);
        send_item(OP_ALLOC, 8, 0);
        send_item(OP_ALLOC, 300, 0);
        send_item(OP_QUERY, 0, 0);
        set_limit(0);
        send_item(OP_ALLOC, 8, 0);
        send_item(OP_QUERY, 0, 0);
        set_limit(131071);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_ALLOC, 48000, 0);
        send_item(OP_ALLOC, 16000, 0);
        set_limit(REGION_BYTES);
        while (live_offsets.size() != 0)
            send_item(OP_FREE, 0, live_offsets[0]);
    endtask

    task automatic random_burst(input int count, input int unsigned max_req);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 19);
            if (k < 9)
                send_item(OP_ALLOC, $urandom_range(0, max_req), $urandom_range(0, 65535));
            else if (k < 17)
                send_item(OP_FREE, $urandom_range(0, 131071), pick_free_offset());
            else if (k < 18)
                send_item(OP_ALLOC, $urandom_range(0, 131071), $urandom_range(0, 65535));
            else
                send_item(2'($urandom_range(2, 3)), $urandom_range(0, 131071),
                          $urandom_range(0, 65535));
        end
    endtask

    // Mixed traffic under several limits; mostly small blocks
    task automatic test_random();
        random_burst(300, 256);
        set_limit($urandom_range(1024, 8192));
        random_burst(200, 512);
        set_limit(REGION_BYTES);
        random_burst(150, 4096);
    endtask

    // Hold the result side so the input queue backs up, then drain fully
    task automatic test_backpressure();
        sink_hold_cycles = 300;
        hold_sink = 1'b1;
        random_burst(12, 128);
        wait_drained();
    endtask

    // Full-rate tail with no idling on either side
    task automatic test_full_rate();
        idle_enabled = 1'b0;
        random_burst(250, 256);
    endtask

    // Result side: random stall bursts, one long hold when asked
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge clk);
                hold_sink = 1'b0;
            end
            else if (idle_enabled && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 8);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[67:0];
            if (expected_results.size() == 0)
            begin
                $display("unexpected result %0d", results_seen);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("ok", got.ok, want.ok);
                if (got.payload !== want.payload)
                    report_mismatch("payload_offset", got.payload, want.payload);
                if (got.used !== want.used)
                    report_mismatch("used_bytes", got.used, want.used);
                if (got.avail !== want.avail)
                    report_mismatch("free_bytes", got.avail, want.avail);
                if (got.high !== want.high)
                    report_mismatch("high_water", got.high, want.high);
            end
            results_seen++;
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_CYCLES)
        begin
            $display("FAIL first_fit_region_allocator");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        results_seen = 0;
        idle_count = 0;
        idle_enabled = 1'b1;
        hold_sink = 1'b0;
        sink_hold_cycles = 0;
        model_end = 0;
        model_in_use = 0;
        model_high = 0;
        model_limit = REGION_BYTES;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            hdr_size[i] = 0;
            hdr_used[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_limits();
        test_random();
        test_backpressure();
        test_full_rate();
        wait_drained();

        $display("covered %0d results over allocate, free, query and odd ops,", results_seen);
        $display("limit changes from 0 to above the region, stalls and a full-rate tail");
        if (error_count == 0)
            $display("PASS first_fit_region_allocator");
        else
            $display("FAIL first_fit_region_allocator");
        $finish;
    end
endmodule
